@@ rtl/crcrld_pkg.sv @@
// shared constants for the crc long division block
package crcrld_pkg;

   localparam int MSG_BITS = 48;
   localparam int GEN_BITS = 17;
   localparam int REM_BITS = GEN_BITS - 1;
   localparam int CNT_W    = $clog2(MSG_BITS + 1);
   localparam int IDX_W    = $clog2(MSG_BITS);
   localparam int SHA_W    = $clog2(REM_BITS);

   localparam logic CSR_GENERATOR = 1'b0;
   localparam logic CSR_GEN_LEN   = 1'b1;

   localparam logic [16:0] GENERATOR_RST = 17'd11;
   localparam logic [4:0]  GEN_LEN_RST   = 5'd4;

endpackage

@@ rtl/crc_remainder_long_division.sv @@
// crc remainder by bit-serial gf(2) long division with configurable generator
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_message[47:0], req_msg_len[5:0]
//   rsp      out        rsp_valid / rsp_stall  rsp_remainder[15:0]
//   csr      in         csr_valid / csr_ready  csr_index, csr_wdata[16:0]
//
// one message bit per cycle through a single shift/xor register, top bit first
// an item goes through accept, one step per message bit (msg_len capped at 48)
// and the result load, with no steps at all when gen_len is below 2
// a new beat is taken while a finished result still waits in the output register
// a stalled result holds the finished remainder in the running state
// reset is synchronous and returns generator and gen_len to 11 and 4
module crc_remainder_long_division
   import crcrld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [47:0] req_message,
   input  logic [5:0]  req_msg_len,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_remainder,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [16:0] csr_wdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [MSG_BITS-1:0] msg_ff, msg_in;
   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [REM_BITS-1:0] genl_ff, genl_in;
   logic [SHA_W-1:0]    sha_ff, sha_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [REM_BITS-1:0] rsp_rem_ff, rsp_rem_in;
   logic [16:0]         generator_ff;
   logic [4:0]          gen_len_ff;

   logic                req_take;
   logic                out_free;
   logic [5:0]          glen_sat;
   logic [CNT_W-1:0]    mlen_sat;
   logic [IDX_W-1:0]    bit_idx;
   logic                fb;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         generator_ff <= GENERATOR_RST;
         gen_len_ff   <= GEN_LEN_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GENERATOR: generator_ff <= csr_wdata;
            CSR_GEN_LEN:   gen_len_ff   <= csr_wdata[4:0];
            default:       ;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign glen_sat = ({1'b0, gen_len_ff} > 6'(GEN_BITS)) ? 6'(GEN_BITS) : {1'b0, gen_len_ff};
   assign mlen_sat = (CNT_W'(req_msg_len) > CNT_W'(MSG_BITS)) ? CNT_W'(MSG_BITS)
                                                               : CNT_W'(req_msg_len);

   assign bit_idx = IDX_W'(cnt_ff - CNT_W'(1));
   // feedback: top of the running remainder against the next message bit
   assign fb      = rem_ff[REM_BITS-1] ^ msg_ff[bit_idx];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      msg_in       = msg_ff;
      rem_in       = rem_ff;
      genl_in      = genl_ff;
      sha_in       = sha_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rem_in   = rsp_rem_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_RUN;
               msg_in   = req_message;
               rem_in   = '0;
               // remainder kept left aligned at the top of the register
               sha_in   = SHA_W'(6'(GEN_BITS) - glen_sat);
               genl_in  = generator_ff[REM_BITS-1:0] << sha_in;
               cnt_in   = (glen_sat < 6'd2) ? '0 : mlen_sat;
            end
         end
         ST_RUN: begin
            if (cnt_ff != '0) begin
               rem_in = (rem_ff << 1) ^ (fb ? genl_ff : '0);
               cnt_in = cnt_ff - CNT_W'(1);
            end else if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_rem_in   = rem_ff >> sha_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff     <= msg_in;
      rem_ff     <= rem_in;
      genl_ff    <= genl_in;
      sha_ff     <= sha_in;
      rsp_rem_ff <= rsp_rem_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_remainder = rsp_rem_ff;

endmodule

@@ sim/tb_top.sv @@
// testbench for the crc remainder long division block: directed and random beats checked against a predictor
`timescale 1ns / 100ps

module tb_top;
   import crcrld_pkg::*;

   typedef struct {
      logic [47:0] message;
      logic [5:0]  msg_len;
   } crc_item_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [47:0] req_message = '0;
   logic [5:0]  req_msg_len = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_remainder;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_GENERATOR;
   logic [16:0] csr_wdata = '0;

   crc_item_type msg_queue[$];
   logic [15:0]  crc_expected[$];
   logic [16:0]  poly_q = GENERATOR_RST;
   logic [4:0]   poly_len_q = GEN_LEN_RST;
   bit           no_gaps = 1'b0;
   int           fail_cnt = 0;

   crc_remainder_long_division uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_message   (req_message),
      .req_msg_len   (req_msg_len),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_remainder (rsp_remainder),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // gf(2) long division of the zero-extended message by the generator
   function automatic logic [15:0] crc_remainder_of(logic [47:0] msg, logic [5:0] len_in,
                                                    logic [16:0] gpoly, logic [4:0] glen_in);
      int unsigned mlen;
      int unsigned glen;
      int unsigned i;
      logic [63:0] dvd;
      logic [63:0] gen;
      mlen = (len_in > MSG_BITS) ? MSG_BITS : len_in;
      glen = (glen_in > GEN_BITS) ? GEN_BITS : glen_in;
      if (glen < 2)
         return '0;
      dvd = 64'(msg) & ((64'd1 << mlen) - 64'd1);
      dvd = dvd << (glen - 1);
      gen = 64'(gpoly) & ((64'd1 << glen) - 64'd1);
      for (i = mlen; i > 0; i--) begin
         if (dvd[i + glen - 2])
            dvd ^= gen << (i - 1);
      end
      return 16'(dvd & ((64'd1 << (glen - 1)) - 64'd1));
   endfunction

   // mostly back to back, sometimes a short gap, rarely a long pause
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // driver
   int           send_gap = 0;
   crc_item_type cur_item;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall)
            crc_expected.push_back(crc_remainder_of(req_message, req_msg_len,
                                                    poly_q, poly_len_q));
         if (req_valid && req_stall) begin
            // stalled beat stays put
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (msg_queue.size() != 0) begin
            cur_item = msg_queue.pop_front();
            req_valid   <= 1'b1;
            req_message <= cur_item.message;
            req_msg_len <= cur_item.msg_len;
            if (!no_gaps)
               send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and receiver stall
   int          stall_left = 0;
   int          long_hold = 0;
   int          rsp_cnt = 0;
   logic [15:0] exp_rem;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         long_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_cnt++;
            if (crc_expected.size() == 0) begin
               fail_cnt++;
               if (fail_cnt <= 20)
                  $display("%0t: unexpected beat, expected none, actual %h",
                           $time, rsp_remainder);
            end else begin
               exp_rem = crc_expected.pop_front();
               if (rsp_remainder !== exp_rem) begin
                  fail_cnt++;
                  if (fail_cnt <= 20)
                     $display("%0t: remainder mismatch, expected %h, actual %h",
                              $time, exp_rem, rsp_remainder);
               end
            end
            // long hold-off so the block fills and pushes back on its input
            if (rsp_cnt == 30 || rsp_cnt == 540)
               long_hold = 400;
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!no_gaps && $urandom_range(0, 3) == 0)
               stall_left = pick_gap();
         end
      end
   end

   task automatic csr_write(logic idx, logic [16:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_GENERATOR)
         poly_q = data;
      else
         poly_len_q = data[4:0];
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (msg_queue.size() != 0 || crc_expected.size() != 0 || req_valid);
   endtask

   task automatic add_item(logic [47:0] msg, logic [5:0] len);
      crc_item_type it;
      it.message = msg;
      it.msg_len = len;
      msg_queue.push_back(it);
   endtask

   task automatic add_random_item();
      logic [47:0] msg;
      logic [5:0]  len;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 5)
         len = 6'd0;
      else if (r < 12)
         len = 6'($urandom_range(49, 63));
      else if (r < 25)
         len = 6'($urandom_range(1, 8));
      else
         len = 6'($urandom_range(1, 48));
      r = $urandom_range(0, 99);
      if (r < 4)
         msg = '1;
      else if (r < 7)
         msg = '0;
      else
         msg = 48'({$urandom, $urandom});
      add_item(msg, len);
   endtask

   initial begin
      logic [16:0] poly_tab[8];
      logic [16:0] len_tab[8];
      logic [16:0] gp;
      logic [4:0]  gl;
      int          n;

      // fixed settings: ccitt-16, saturated length, shortest, lengths of zero and one,
      // generator without its leading one, crc-8 with junk above the length field
      poly_tab = '{17'h0_000b, 17'h1_1021, 17'h1_ffff, 17'h0_0003,
                   17'h0_0000, 17'h0_0007, 17'h0_0005, 17'h0_0107};
      len_tab  = '{17'd4, 17'd17, 17'h1_ffff, 17'd2,
                   17'd0, 17'd1, 17'd8, 17'h1_ffe9};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed beats at the reset setting
      add_item(48'hffff_ffff_ffff, 6'd0);
      add_item(48'h0, 6'd1);
      add_item(48'h1, 6'd1);
      add_item(48'hffff_ffff_ffff, 6'd1);
      add_item(48'hffff_ffff_ffff, 6'd48);
      add_item(48'h0, 6'd48);
      add_item(48'h1, 6'd48);
      add_item(48'h8000_0000_0000, 6'd48);
      add_item(48'ha5a5_5a5a_c3c3, 6'd48);
      add_item(48'hffff_ffff_ffff, 6'd63);
      add_item(48'h1234_5678_9abc, 6'd49);
      add_item(48'hffff_ffff_fff6, 6'd4);
      add_item(48'h0000_0000_0006, 6'd3);
      add_item(48'h0000_dead_beef, 6'd32);
      add_item(48'h5555_5555_5555, 6'd47);
      add_item(48'haaaa_aaaa_aaaa, 6'd48);
      add_item(48'h0000_0000_000b, 6'd4);
      add_item(48'h0000_0000_0008, 6'd4);
      for (n = 0; n < 60; n++)
         add_random_item();
      wait_drained();

      for (int p = 1; p < 12; p++) begin
         if (p < 8) begin
            gp = poly_tab[p];
            csr_write(CSR_GENERATOR, gp);
            csr_write(CSR_GEN_LEN, len_tab[p]);
         end else begin
            gl = ($urandom_range(0, 99) < 80) ? 5'($urandom_range(2, 17))
                                               : 5'($urandom_range(0, 31));
            gp = 17'($urandom_range(0, 17'h1_ffff));
            if (gl >= 2 && gl <= 17 && $urandom_range(0, 3) != 0)
               gp[gl - 1] = 1'b1;
            csr_write(CSR_GENERATOR, gp);
            csr_write(CSR_GEN_LEN, {12'($urandom_range(0, 4095)), gl});
         end
         no_gaps = (p == 3 || p == 9);
         @(negedge clock);
         for (n = 0; n < 85; n++)
            add_random_item();
         wait_drained();
      end

      repeat (60) @(posedge clock);
      if (fail_cnt == 0 && crc_expected.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/crcrld_pkg.sv
rtl/crc_remainder_long_division.sv
sim/tb_top.sv
